### src/u8u16_pkg.sv
// ============================================================================
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ============================================================================
`default_nettype none

package u8u16_pkg;

    // payload widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 2;

    // register port
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned REG_IDX_W = 1;
    localparam int unsigned ADDR_W    = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_WIDE_UNIT_MODE = 1'b0;

    // unicode limits
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] PLANE1    = 21'h010000;
    localparam logic [CP_W-1:0] FLOOR_2B  = 21'h000080;
    localparam logic [CP_W-1:0] FLOOR_3B  = 21'h000800;
    localparam logic [15:0]     HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0]     LOW_SURR_BASE  = 16'hDC00;

    // queue between decoder and unit stage
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // one decoded code point, or the error mark at string end
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last;
        logic            err;
    } entry_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // range, overlong and surrogate check of a completed sequence
    function automatic logic value_ok(input logic [CP_W-1:0] v, input logic [LEN_W-1:0] conts);
        logic [CP_W-1:0] floor_v;
        case (conts)
            2'd1:    floor_v = FLOOR_2B;
            2'd2:    floor_v = FLOOR_3B;
            2'd3:    floor_v = PLANE1;
            default: floor_v = '0;
        endcase
        return (v >= floor_v) && (v <= CP_MAX) && !((v >= SURR_LO) && (v <= SURR_HI));
    endfunction

endpackage

`default_nettype wire

### src/u8u16_in_if.sv
// ============================================================================
// u8u16_in_if
// Byte channel: one UTF-8 byte per word with an end-of-string mark.
// ============================================================================
`default_nettype none

interface u8u16_in_if;

    logic                          valid;
    logic                          ready;
    logic [u8u16_pkg::BYTE_W-1:0]  byte_in;
    logic                          end_of_string;

    modport source (output valid, output byte_in, output end_of_string, input ready);
    modport sink   (input valid, input byte_in, input end_of_string, output ready);

endinterface

`default_nettype wire

### src/u8u16_out_if.sv
// ============================================================================
// u8u16_out_if
// Unit channel: one UTF-16 code unit or wide code point per word.
// ============================================================================
`default_nettype none

interface u8u16_out_if;

    logic                        valid;
    logic                        ready;
    logic [u8u16_pkg::CP_W-1:0]  code_unit;
    logic                        string_end;
    logic                        error;

    modport source (output valid, output code_unit, output string_end, output error,
                    input ready);
    modport sink   (input valid, input code_unit, input string_end, input error,
                    output ready);

endinterface

`default_nettype wire

### src/u8u16_front.sv
// ============================================================================
// u8u16_front
// Byte decoder: accepts one byte a cycle unless the queue is full, tracks the
// open sequence and queues each finished code point or string error.
// ============================================================================
`default_nettype none

module u8u16_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    u8u16_in_if.sink                  byte_ch,
    input  wire u8u16_pkg::q_status_t q_status,
    output logic                      push,
    output u8u16_pkg::entry_t         push_entry
);

    logic [u8u16_pkg::CP_W-1:0]  partial_reg, partial_next;
    logic [u8u16_pkg::LEN_W-1:0] remaining_reg, remaining_next;
    logic [u8u16_pkg::LEN_W-1:0] seqlen_reg, seqlen_next;
    logic                        err_reg, err_next;

    logic                        accept;
    logic                        done;
    logic [u8u16_pkg::CP_W-1:0]  cp;
    logic [u8u16_pkg::CP_W-1:0]  shifted;
    logic [7:0]                  b;

    assign byte_ch.ready = !q_status.full;
    assign accept        = byte_ch.valid && !q_status.full;
    assign b             = byte_ch.byte_in;
    assign shifted       = {partial_reg[u8u16_pkg::CP_W-7:0], b[5:0]};

    // decode step
    always_comb
    begin
        partial_next   = partial_reg;
        remaining_next = remaining_reg;
        seqlen_next    = seqlen_reg;
        err_next       = err_reg;
        done           = 1'b0;
        cp             = '0;
        push           = 1'b0;
        push_entry     = '0;
        if (accept)
        begin
            if (!err_reg)
            begin
                if (remaining_reg == 2'd0)
                begin
                    if (!b[7])
                    begin
                        cp   = {13'd0, b};
                        done = 1'b1;
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        partial_next   = {16'd0, b[4:0]};
                        remaining_next = 2'd1;
                        seqlen_next    = 2'd1;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        partial_next   = {17'd0, b[3:0]};
                        remaining_next = 2'd2;
                        seqlen_next    = 2'd2;
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        partial_next   = {18'd0, b[2:0]};
                        remaining_next = 2'd3;
                        seqlen_next    = 2'd3;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else if (b[7:6] != 2'b10)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    partial_next   = shifted;
                    remaining_next = remaining_reg - 2'd1;
                    if (remaining_reg == 2'd1)
                    begin
                        if (u8u16_pkg::value_ok(shifted, seqlen_reg))
                        begin
                            cp   = shifted;
                            done = 1'b1;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                        partial_next = '0;
                        seqlen_next  = '0;
                    end
                end
            end

            // string end reports the error, else a finished code point leaves
            if (byte_ch.end_of_string && (err_next || remaining_next != 2'd0))
            begin
                push                  = 1'b1;
                push_entry.code_point = '0;
                push_entry.last       = 1'b1;
                push_entry.err        = 1'b1;
            end
            else if (done)
            begin
                push                  = 1'b1;
                push_entry.code_point = cp;
                push_entry.last       = byte_ch.end_of_string;
                push_entry.err        = 1'b0;
            end

            if (byte_ch.end_of_string)
            begin
                partial_next   = '0;
                remaining_next = '0;
                seqlen_next    = '0;
                err_next       = 1'b0;
            end
        end
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            remaining_reg <= '0;
            seqlen_reg    <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            partial_reg   <= partial_next;
            remaining_reg <= remaining_next;
            seqlen_reg    <= seqlen_next;
            err_reg       <= err_next;
        end
    end

`ifndef SYNTHESIS
    // string end leaves the decoder clean for the next string
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_ch.end_of_string |=> remaining_reg == 2'd0 && seqlen_reg == 2'd0
            && !err_reg && partial_reg == '0)
        else $error("decoder state not cleared after string end");

    // continuation count never exceeds the sequence length
    assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg <= seqlen_reg)
        else $error("continuation count above sequence length");
`endif

endmodule

`default_nettype wire

### src/u8u16_fifo.sv
// ============================================================================
// u8u16_fifo
// Short queue of decoded entries between the decoder and the unit stage.
// ============================================================================
`default_nettype none

module u8u16_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire u8u16_pkg::entry_t     push_entry,
    input  wire logic                  pop,
    output u8u16_pkg::entry_t          head,
    output u8u16_pkg::q_status_t       q_status
);

    u8u16_pkg::entry_t             slot_reg [u8u16_pkg::QDEPTH];
    logic [u8u16_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [u8u16_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                          do_push, do_pop;

    assign q_status.full  = (count_reg == u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    // occupancy never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH))
        else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

### src/u8u16_back.sv
// ============================================================================
// u8u16_back
// Unit stage: turns queued code points into UTF-16 units or wide units,
// splitting supplementary code points into surrogate pairs.
// ============================================================================
`default_nettype none

module u8u16_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wide_unit_mode,
    input  wire u8u16_pkg::entry_t     head,
    input  wire u8u16_pkg::q_status_t  q_status,
    output logic                       pop,
    u8u16_out_if.source                unit_ch
);

    logic                        out_valid_reg, out_valid_next;
    logic [u8u16_pkg::CP_W-1:0]  out_unit_reg, out_unit_next;
    logic                        out_end_reg, out_end_next;
    logic                        out_err_reg, out_err_next;
    logic                        phase_reg, phase_next;

    logic                        load;
    logic                        pair;
    logic [u8u16_pkg::CP_W-1:0]  offset;
    logic [u8u16_pkg::CP_W-1:0]  hi_unit, lo_unit;

    assign load    = !out_valid_reg || unit_ch.ready;
    assign pair    = !wide_unit_mode && !head.err && (head.code_point[20:16] != 5'd0);
    assign offset  = head.code_point - u8u16_pkg::PLANE1;
    assign hi_unit = {5'd0, u8u16_pkg::HIGH_SURR_BASE | {6'd0, offset[19:10]}};
    assign lo_unit = {5'd0, u8u16_pkg::LOW_SURR_BASE | {6'd0, offset[9:0]}};
    assign pop     = load && !q_status.empty && (!pair || phase_reg);

    // next output word
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_unit_next  = out_unit_reg;
        out_end_next   = out_end_reg;
        out_err_next   = out_err_reg;
        phase_next     = phase_reg;
        if (load)
        begin
            out_valid_next = !q_status.empty;
            if (!q_status.empty)
            begin
                out_err_next = head.err;
                if (pair)
                begin
                    out_unit_next = phase_reg ? lo_unit : hi_unit;
                    out_end_next  = head.last && phase_reg;
                    phase_next    = !phase_reg;
                end
                else
                begin
                    out_unit_next = head.code_point;
                    out_end_next  = head.last;
                    phase_next    = 1'b0;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        out_unit_reg <= out_unit_next;
        out_end_reg  <= out_end_next;
        out_err_reg  <= out_err_next;
    end

    assign unit_ch.valid      = out_valid_reg;
    assign unit_ch.code_unit  = out_unit_reg;
    assign unit_ch.string_end = out_end_reg;
    assign unit_ch.error      = out_err_reg;

`ifndef SYNTHESIS
    // an error word closes its string and carries no unit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_end_reg && out_unit_reg == '0)
        else $error("error word without string end or with nonzero unit");

    // the second half of a pair always has its entry still queued
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> !q_status.empty)
        else $error("low surrogate pending with empty queue");
`endif

endmodule

`default_nettype wire

### src/utf8_to_utf16_transcoder_core.sv
// ============================================================================
// utf8_to_utf16_transcoder_core
// UTF-8 to UTF-16 / wide transcoder: decoder, entry queue, unit stage and
// register port.
// ============================================================================
//
//  channel   dir  words              payload
//  byte_ch   in   one byte           byte_in[7:0], end_of_string
//  unit_ch   out  one code unit      code_unit[20:0], string_end, error
//  apb       in   register access    wide_unit_mode at byte address 0
//
//  One byte is taken every cycle while the four-entry queue has room; a byte
//  reaches unit_ch through the queue slot and then the output register.
//  The unit stage sends one word a cycle unless unit_ch stalls; a surrogate
//  pair is sent as two words. Reset clears the control state at once, there
//  is no clearing pass; queue slots and the output word are not reset.
//  A stall on unit_ch fills the queue and then holds byte_ch.ready low.
`default_nettype none

module utf8_to_utf16_transcoder_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    u8u16_in_if.sink                              byte_ch,
    u8u16_out_if.source                           unit_ch,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [u8u16_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [u8u16_pkg::DATA_W-1:0]     pwdata,
    output logic      [u8u16_pkg::DATA_W-1:0]     prdata,
    output logic                                  pready
);

    logic                  wide_mode_reg;
    logic                  reg_hit;
    logic                  push;
    logic                  pop;
    u8u16_pkg::entry_t     push_entry;
    u8u16_pkg::entry_t     head;
    u8u16_pkg::q_status_t  q_status;

    // register port
    assign pready  = 1'b1;
    assign reg_hit = (paddr[u8u16_pkg::ADDR_W-1:2] == u8u16_pkg::REG_WIDE_UNIT_MODE);
    assign prdata  = reg_hit ? {{(u8u16_pkg::DATA_W-1){1'b0}}, wide_mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            wide_mode_reg <= pwdata[0];
        end
    end

    // decoder
    u8u16_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // entry queue
    u8u16_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    // unit stage
    u8u16_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .wide_unit_mode (wide_mode_reg),
        .head           (head),
        .q_status       (q_status),
        .pop            (pop),
        .unit_ch        (unit_ch)
    );

endmodule

`default_nettype wire

### tb/utf8_to_utf16_transcoder_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// utf8_to_utf16_transcoder_core_tb
// Drives UTF-8 strings, directed and random, well-formed and broken, into the
// byte channel with random gaps, stalls the unit channel at random, and
// checks every unit word against an in-bench decoder in both unit modes.
// ============================================================================

module utf8_to_utf16_transcoder_core_tb;

    // unicode limits of the in-bench decoder
    localparam logic [20:0] TOP_SCALAR     = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST     = 21'h00D800;
    localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
    localparam logic [20:0] BMP_LAST       = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE      = 21'h010000;
    localparam logic [15:0] HI_SURR_PREFIX = 16'hD800;
    localparam logic [15:0] LO_SURR_PREFIX = 16'hDC00;

    localparam logic UNIT_MODE_UTF16 = 1'b0;
    localparam logic UNIT_MODE_WIDE  = 1'b1;

    localparam logic [u8u16_pkg::ADDR_W-1:0] MODE_ADDR =
        {u8u16_pkg::REG_WIDE_UNIT_MODE, 2'b00};

    // pause after the last word, covers queue depth plus pipeline
    localparam int SETTLE_CYCLES = 10;
    localparam int PRINT_LIMIT   = 30;

    typedef enum int {
        FAULT_NONE,
        FAULT_BAD_LEAD,
        FAULT_BAD_CONT,
        FAULT_OVERLONG,
        FAULT_TOO_BIG,
        FAULT_SURROGATE,
        FAULT_TRUNCATED,
        FAULT_NOISE
    } fault_e;

    typedef struct packed {
        logic [u8u16_pkg::CP_W-1:0] code_unit;
        logic                       string_end;
        logic                       error;
    } unit_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [u8u16_pkg::ADDR_W-1:0] paddr;
    logic [u8u16_pkg::DATA_W-1:0] pwdata;
    logic [u8u16_pkg::DATA_W-1:0] prdata;
    logic                         pready;

    u8u16_in_if  byte_ch ();
    u8u16_out_if unit_ch ();

    utf8_to_utf16_transcoder_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .unit_ch (unit_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // decoder state mirrored in the bench
    logic        wide_mode;
    logic [20:0] acc_cp;
    logic [1:0]  conts_due;
    logic [1:0]  seq_conts;
    logic        str_bad;

    unit_word_t  pending_units[$];
    logic [7:0]  str_bytes[$];

    int idle_pct;
    int stall_pct;
    int mismatches;
    int bytes_sent;
    int strings_sent;
    int units_checked;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int pick_gap(input int pct, input int long_max);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(6, long_max);
        return $urandom_range(1, 2);
    endfunction

    // --------------------------------------------------------------------
    // decoder model
    // --------------------------------------------------------------------

    function automatic logic scalar_legal(input logic [20:0] v, input logic [1:0] conts);
        logic [20:0] lowest;
        case (conts)
            2'd1:    lowest = 21'h000080;
            2'd2:    lowest = 21'h000800;
            2'd3:    lowest = SUPP_BASE;
            default: lowest = '0;
        endcase
        return (v >= lowest) && (v <= TOP_SCALAR) && !((v >= SURR_FIRST) && (v <= SURR_LAST));
    endfunction

    task automatic queue_unit(input logic [20:0] cu, input logic se, input logic er);
        unit_word_t w;
        w.code_unit  = cu;
        w.string_end = se;
        w.error      = er;
        pending_units = {pending_units, w};
    endtask

    // update decoder state with one byte and queue the words it yields
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic [20:0] cp;
        logic [19:0] off;
        logic        emit;
        cp   = '0;
        emit = 1'b0;
        if (!str_bad)
        begin
            if (conts_due == 2'd0)
            begin
                if (b[7] == 1'b0)
                begin
                    cp   = {13'd0, b};
                    emit = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    acc_cp    = {16'd0, b[4:0]};
                    conts_due = 2'd1;
                    seq_conts = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    acc_cp    = {17'd0, b[3:0]};
                    conts_due = 2'd2;
                    seq_conts = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    acc_cp    = {18'd0, b[2:0]};
                    conts_due = 2'd3;
                    seq_conts = 2'd3;
                end
                else
                    str_bad = 1'b1;
            end
            else if (b[7:6] != 2'b10)
                str_bad = 1'b1;
            else
            begin
                acc_cp    = {acc_cp[14:0], b[5:0]};
                conts_due = conts_due - 2'd1;
                if (conts_due == 2'd0)
                begin
                    if (scalar_legal(acc_cp, seq_conts))
                    begin
                        cp   = acc_cp;
                        emit = 1'b1;
                    end
                    else
                        str_bad = 1'b1;
                    acc_cp    = '0;
                    seq_conts = '0;
                end
            end
        end

        // end byte of a broken or truncated string: one error word
        if (eos && (str_bad || conts_due != 2'd0))
            queue_unit('0, 1'b1, 1'b1);
        else if (emit)
        begin
            if (wide_mode == UNIT_MODE_UTF16 && cp > BMP_LAST)
            begin
                off = 20'(cp - SUPP_BASE);
                queue_unit({5'd0, HI_SURR_PREFIX | {6'd0, off[19:10]}}, 1'b0, 1'b0);
                queue_unit({5'd0, LO_SURR_PREFIX | {6'd0, off[9:0]}}, eos, 1'b0);
            end
            else
                queue_unit(cp, eos, 1'b0);
        end

        if (eos)
        begin
            acc_cp    = '0;
            conts_due = '0;
            seq_conts = '0;
            str_bad   = 1'b0;
        end
    endtask

    // --------------------------------------------------------------------
    // unit channel: random stalls and word check
    // --------------------------------------------------------------------

    initial
    begin
        int stall_left;
        stall_left = 0;
        unit_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                unit_ch.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                unit_ch.ready <= 1'b0;
                stall_left = pick_gap(100, 30) - 1;
            end
            else
                unit_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        unit_word_t want;
        if (rst_n && unit_ch.valid && unit_ch.ready)
        begin
            if (pending_units.size() == 0)
                report_mismatch($sformatf("unexpected word code_unit=%06h string_end=%0b error=%0b",
                                          unit_ch.code_unit, unit_ch.string_end, unit_ch.error));
            else
            begin
                want = pending_units.pop_front();
                units_checked++;
                if (unit_ch.code_unit !== want.code_unit)
                    report_mismatch($sformatf("code_unit %06h, want %06h",
                                              unit_ch.code_unit, want.code_unit));
                if (unit_ch.string_end !== want.string_end)
                    report_mismatch($sformatf("string_end %0b, want %0b (code_unit %06h)",
                                              unit_ch.string_end, want.string_end,
                                              want.code_unit));
                if (unit_ch.error !== want.error)
                    report_mismatch($sformatf("error %0b, want %0b (code_unit %06h)",
                                              unit_ch.error, want.error, want.code_unit));
            end
        end
    end

    // --------------------------------------------------------------------
    // byte channel and register port
    // --------------------------------------------------------------------

    // hand one byte to the block, returns at the edge that takes it
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = pick_gap(idle_pct, 20);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.byte_in       <= b;
        byte_ch.end_of_string <= eos;
        decode_byte(b, eos);
        do @(posedge clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++)
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        strings_sent++;
    endtask

    // stop sending and wait until every pending word has come out
    task automatic drain_units();
        byte_ch.valid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup and access phases, then psel is dropped before the next access
    task automatic apb_access(input logic wr, input logic [u8u16_pkg::ADDR_W-1:0] a,
                              input logic [u8u16_pkg::DATA_W-1:0] wd,
                              output logic [u8u16_pkg::DATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= wd;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_unit_mode(input logic mode);
        logic [u8u16_pkg::DATA_W-1:0] rd;
        apb_access(1'b1, MODE_ADDR, u8u16_pkg::DATA_W'(mode), rd);
        wide_mode = mode;
        apb_access(1'b0, MODE_ADDR, '0, rd);
        if (rd !== u8u16_pkg::DATA_W'(mode))
            report_mismatch($sformatf("wide_unit_mode reads %08h, want %0b", rd, mode));
    endtask

    // --------------------------------------------------------------------
    // random string builder
    // --------------------------------------------------------------------

    // add one byte at the tail of the string being built
    task automatic append_byte(input logic [7:0] b);
        str_bytes = {str_bytes, b};
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'($urandom_range('h80, 'hBF));
    endfunction

    task automatic put_scalar(input logic [20:0] cp);
        if (cp < 21'h80)
            append_byte(cp[7:0]);
        else if (cp < 21'h800)
        begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
        end
        else if (cp < SUPP_BASE)
        begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end
        else
        begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end
    endtask

    // legal scalar, mostly short forms; surrogates folded into F800..FFFF
    function automatic logic [20:0] rand_scalar(input int min_len);
        int          r;
        logic [20:0] cp;
        r = $urandom_range(min_len > 1 ? 4 : 0, 9);
        if (r < 4)
            cp = 21'($urandom_range(0, 'h7F));
        else if (r < 6)
            cp = 21'($urandom_range('h80, 'h7FF));
        else if (r < 8)
        begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= SURR_FIRST && cp <= SURR_LAST)
                cp = cp ^ 21'h002000;
        end
        else
            cp = 21'($urandom_range('h10000, 'h10FFFF));
        return cp;
    endfunction

    task automatic put_fault(input fault_e kind);
        int start;
        int cut;
        case (kind)
            FAULT_BAD_LEAD:
                append_byte($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                                 : 8'($urandom_range('hF8, 'hFF)));
            FAULT_BAD_CONT:
            begin
                append_byte(8'($urandom_range('hE1, 'hEC)));
                append_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F))
                                                 : 8'($urandom_range('hC0, 'hFF)));
                append_byte(rand_cont());
            end
            FAULT_OVERLONG:
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        append_byte(8'($urandom_range('hC0, 'hC1)));
                        append_byte(rand_cont());
                    end
                    1:
                    begin
                        append_byte(8'hE0);
                        append_byte(8'($urandom_range('h80, 'h9F)));
                        append_byte(rand_cont());
                    end
                    default:
                    begin
                        append_byte(8'hF0);
                        append_byte(8'($urandom_range('h80, 'h8F)));
                        append_byte(rand_cont());
                        append_byte(rand_cont());
                    end
                endcase
            end
            FAULT_TOO_BIG:
            begin
                if ($urandom_range(0, 1))
                begin
                    append_byte(8'hF4);
                    append_byte(8'($urandom_range('h90, 'hBF)));
                end
                else
                begin
                    append_byte(8'($urandom_range('hF5, 'hF7)));
                    append_byte(rand_cont());
                end
                append_byte(rand_cont());
                append_byte(rand_cont());
            end
            FAULT_SURROGATE:
            begin
                append_byte(8'hED);
                append_byte(8'($urandom_range('hA0, 'hBF)));
                append_byte(rand_cont());
            end
            FAULT_TRUNCATED:
            begin
                start = str_bytes.size();
                put_scalar(rand_scalar(2));
                cut = $urandom_range(1, str_bytes.size() - start - 1);
                repeat (cut) void'(str_bytes.pop_back());
            end
            FAULT_NOISE:
                repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
            default:
                ;
        endcase
    endtask

    // a string of legal scalars with at most one fault spliced in
    task automatic build_string();
        int     n;
        int     at;
        fault_e kind;
        str_bytes.delete();
        n    = $urandom_range(0, 8);
        kind = FAULT_NONE;
        if ($urandom_range(0, 99) < 30)
            kind = fault_e'($urandom_range(FAULT_BAD_LEAD, FAULT_NOISE));
        at = (kind == FAULT_TRUNCATED) ? n : $urandom_range(0, n);
        for (int i = 0; i <= n; i++)
        begin
            if (i == at)
                put_fault(kind);
            if (i < n)
                put_scalar(rand_scalar(1));
        end
        if (str_bytes.size() == 0)
            append_byte(8'($urandom_range(0, 'h7F)));
    endtask

    task automatic run_random_strings(input int byte_budget);
        int goal;
        goal = bytes_sent + byte_budget;
        while (bytes_sent < goal)
        begin
            build_string();
            send_string();
        end
    endtask

    // --------------------------------------------------------------------
    // tests
    // --------------------------------------------------------------------

    // extremes of every sequence length and the main error paths, UTF-16 units
    task automatic test_directed_utf16();
        idle_pct  = 20;
        stall_pct = 20;
        set_unit_mode(UNIT_MODE_UTF16);
        // 00, 7F, 80, 7FF, 800, FFFF, 10000, 10FFFF; last one a pair at string end
        str_bytes = {8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
                     8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
                     8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        // stray continuation as the only byte
        str_bytes = {8'h80};
        send_string();
        // unit before an overlong form, then a byte after the error
        str_bytes = {8'h41, 8'hC0, 8'h80, 8'h42};
        send_string();
        // string ends inside a sequence
        str_bytes = {8'hE2, 8'h82};
        send_string();
        drain_units();
    endtask

    // supplementary scalars as single wide units
    task automatic test_directed_wide();
        set_unit_mode(UNIT_MODE_WIDE);
        str_bytes = {8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        drain_units();
    endtask

    task automatic test_random_wide();
        idle_pct  = 25;
        stall_pct = 25;
        run_random_strings(250);
        drain_units();
    endtask

    task automatic test_random_utf16();
        set_unit_mode(UNIT_MODE_UTF16);
        idle_pct  = 30;
        stall_pct = 15;
        run_random_strings(250);
        drain_units();
    endtask

    // full rate on both sides
    task automatic test_random_no_gaps();
        set_unit_mode(UNIT_MODE_WIDE);
        idle_pct  = 0;
        stall_pct = 0;
        run_random_strings(200);
        drain_units();
    endtask

    // heavy stalls so the queue fills and holds the byte channel
    task automatic test_random_back_pressure();
        set_unit_mode(UNIT_MODE_UTF16);
        idle_pct  = 0;
        stall_pct = 60;
        run_random_strings(200);
        drain_units();
    endtask

    initial
    begin
        wide_mode     = UNIT_MODE_UTF16;
        acc_cp        = '0;
        conts_due     = '0;
        seq_conts     = '0;
        str_bad       = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        mismatches    = 0;
        bytes_sent    = 0;
        strings_sent  = 0;
        units_checked = 0;

        rst_n                 <= 1'b0;
        byte_ch.valid         <= 1'b0;
        byte_ch.byte_in       <= '0;
        byte_ch.end_of_string <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_utf16();
        test_directed_wide();
        test_random_wide();
        test_random_utf16();
        test_random_no_gaps();
        test_random_back_pressure();

        $display("sent %0d bytes in %0d strings, checked %0d words", bytes_sent,
                 strings_sent, units_checked);
        $display("covered UTF-16 and wide unit modes, broken strings, gaps and stalls");
        if (mismatches == 0 && pending_units.size() == 0)
            $display("utf8_to_utf16_transcoder_core_tb OK");
        else
            $display("utf8_to_utf16_transcoder_core_tb NOT OK");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("timeout with %0d words pending", pending_units.size());
        $display("utf8_to_utf16_transcoder_core_tb NOT OK");
        $finish;
    end

endmodule
